/* hw/rtl/kuz_pkg.sv */
package kuz_pkg;

    localparam int NumRounds = 10;
    localparam int NumKeyWords = 4;
    localparam int NumSteps = 32;
    localparam int StepsPerPair = 8;

    typedef logic [127:0] block_t;

    typedef enum logic [1:0] {
        CFG_KEY_0 = 2'd0,
        CFG_KEY_1 = 2'd1,
        CFG_KEY_2 = 2'd2,
        CFG_KEY_3 = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXPAND = 4'b0010,
        ST_ENC    = 4'b0100,
        ST_OUT    = 4'b1000
    } state_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] pi [256];
        pi = '{
            8'd252, 8'd238, 8'd221, 8'd17, 8'd207, 8'd110, 8'd49, 8'd22,
            8'd251, 8'd196, 8'd250, 8'd218, 8'd35, 8'd197, 8'd4, 8'd77,
            8'd233, 8'd119, 8'd240, 8'd219, 8'd147, 8'd46, 8'd153, 8'd186,
            8'd23, 8'd54, 8'd241, 8'd187, 8'd20, 8'd205, 8'd95, 8'd193,
            8'd249, 8'd24, 8'd101, 8'd90, 8'd226, 8'd92, 8'd239, 8'd33,
            8'd129, 8'd28, 8'd60, 8'd66, 8'd139, 8'd1, 8'd142, 8'd79,
            8'd5, 8'd132, 8'd2, 8'd174, 8'd227, 8'd106, 8'd143, 8'd160,
            8'd6, 8'd11, 8'd237, 8'd152, 8'd127, 8'd212, 8'd211, 8'd31,
            8'd235, 8'd52, 8'd44, 8'd81, 8'd234, 8'd200, 8'd72, 8'd171,
            8'd242, 8'd42, 8'd104, 8'd162, 8'd253, 8'd58, 8'd206, 8'd204,
            8'd181, 8'd112, 8'd14, 8'd86, 8'd8, 8'd12, 8'd118, 8'd18,
            8'd191, 8'd114, 8'd19, 8'd71, 8'd156, 8'd183, 8'd93, 8'd135,
            8'd21, 8'd161, 8'd150, 8'd41, 8'd16, 8'd123, 8'd154, 8'd199,
            8'd243, 8'd145, 8'd120, 8'd111, 8'd157, 8'd158, 8'd178, 8'd177,
            8'd50, 8'd117, 8'd25, 8'd61, 8'd255, 8'd53, 8'd138, 8'd126,
            8'd109, 8'd84, 8'd198, 8'd128, 8'd195, 8'd189, 8'd13, 8'd87,
            8'd223, 8'd245, 8'd36, 8'd169, 8'd62, 8'd168, 8'd67, 8'd201,
            8'd215, 8'd121, 8'd214, 8'd246, 8'd124, 8'd34, 8'd185, 8'd3,
            8'd224, 8'd15, 8'd236, 8'd222, 8'd122, 8'd148, 8'd176, 8'd188,
            8'd220, 8'd232, 8'd40, 8'd80, 8'd78, 8'd51, 8'd10, 8'd74,
            8'd167, 8'd151, 8'd96, 8'd115, 8'd30, 8'd0, 8'd98, 8'd68,
            8'd26, 8'd184, 8'd56, 8'd130, 8'd100, 8'd159, 8'd38, 8'd65,
            8'd173, 8'd69, 8'd70, 8'd146, 8'd39, 8'd94, 8'd85, 8'd47,
            8'd140, 8'd163, 8'd165, 8'd125, 8'd105, 8'd213, 8'd149, 8'd59,
            8'd7, 8'd88, 8'd179, 8'd64, 8'd134, 8'd172, 8'd29, 8'd247,
            8'd48, 8'd55, 8'd107, 8'd228, 8'd136, 8'd217, 8'd231, 8'd137,
            8'd225, 8'd27, 8'd131, 8'd73, 8'd76, 8'd63, 8'd248, 8'd254,
            8'd141, 8'd83, 8'd170, 8'd144, 8'd202, 8'd216, 8'd133, 8'd97,
            8'd32, 8'd113, 8'd103, 8'd164, 8'd45, 8'd43, 8'd9, 8'd91,
            8'd203, 8'd155, 8'd37, 8'd208, 8'd190, 8'd229, 8'd108, 8'd82,
            8'd89, 8'd166, 8'd116, 8'd210, 8'd230, 8'd244, 8'd180, 8'd192,
            8'd209, 8'd102, 8'd175, 8'd194, 8'd57, 8'd75, 8'd99, 8'd182
        };
        return pi[x];
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] s;
        r = '0;
        s = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r = r ^ s;
            s = s[7] ? ((s << 1) ^ 8'hC3) : (s << 1);
        end
        return r;
    endfunction

    function automatic logic [7:0] lcoef(input int k);
        logic [7:0] c [16];
        c = '{8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1, 8'd251,
              8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148, 8'd1};
        return c[k];
    endfunction

    // byte k of a block sits at bits [127-8k -: 8]
    function automatic block_t rstep(input block_t b);
        logic [7:0] acc;
        acc = '0;
        for (int k = 0; k < 16; k++) acc = acc ^ gf_mul(b[127 - 8 * k -: 8], lcoef(k));
        return {acc, b[127:8]};
    endfunction

    function automatic block_t lin(input block_t b);
        block_t t;
        t = b;
        for (int r = 0; r < 16; r++) t = rstep(t);
        return t;
    endfunction

    function automatic block_t sub_bytes(input block_t b);
        block_t t;
        for (int k = 0; k < 16; k++) t[8 * k +: 8] = sbox(b[8 * k +: 8]);
        return t;
    endfunction

endpackage

/* hw/rtl/kuznyechik_block_encrypt.sv */
// Kuznyechik block encryption, 128-bit block, 256-bit key.
// s_axis beat: tdata = {plain_low, plain_high}, plain_high in bits 63:0.
// m_axis beat: tdata = {cipher_low, cipher_high}, cipher_high in bits 63:0.
// Key words are to be written through cfg_we/cfg_index/cfg_data only while no block
// is in flight; the block does not enforce this. Index 0..3 selects key_word_0..3.
// Any key write forces a new key schedule. The first block after reset or after a
// key write runs the key schedule first: 32 Feistel steps, one per cycle on the
// shared round unit. Encryption runs on the same unit: nine S-box/L rounds, one
// per cycle, then the final key XOR.
// s_axis_tready is low from acceptance until the output beat is taken, so one
// block is in flight. A stalled receiver holds the output beat and the input
// stays blocked.
// Reset clears the key words and the output; no beat is pending after reset.
module kuznyechik_block_encrypt (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // plain_high [63:0], plain_low [127:64]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // cipher_high [63:0], cipher_low [127:64]
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    import kuz_pkg::*;

    logic [63:0]  key_reg [NumKeyWords];
    logic [127:0] rk_mem [NumRounds];
    logic         ready_reg;
    state_t       state_reg;
    block_t       data_reg, a1_reg, a0_reg;
    logic [4:0]   cnt_reg;
    logic [3:0]   rnd_reg;
    block_t       rkey_reg;
    block_t       unit_in, unit_key, unit_out;

    // shared round unit: L(S(x ^ k))
    assign unit_out = lin(sub_bytes(unit_in ^ unit_key));
    assign unit_in  = (state_reg == ST_EXPAND) ? a1_reg : data_reg;
    assign unit_key = (state_reg == ST_EXPAND) ? lin({120'd0, 3'd0, cnt_reg} + 128'd1) : rkey_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {data_reg[63:0], data_reg[127:64]};

    always_ff @(posedge clk)
    begin
        rkey_reg <= rk_mem[rnd_reg];
        if (state_reg == ST_IDLE && s_axis_tvalid && !ready_reg) begin
            rk_mem[0] <= {key_reg[0], key_reg[1]};
            rk_mem[1] <= {key_reg[2], key_reg[3]};
        end else if (state_reg == ST_EXPAND && cnt_reg[2:0] == 3'(StepsPerPair - 1)) begin
            rk_mem[{cnt_reg[4:3], 1'b0} + 4'd2] <= unit_out ^ a0_reg;
            rk_mem[{cnt_reg[4:3], 1'b0} + 4'd3] <= a1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
            cnt_reg   <= '0;
            rnd_reg   <= '0;
            data_reg  <= '0;
            a1_reg    <= '0;
            a0_reg    <= '0;
            for (int i = 0; i < NumKeyWords; i++) key_reg[i] <= '0;
        end else begin
            if (cfg_we) begin
                key_reg[cfg_index] <= cfg_data;
                ready_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid) begin
                        data_reg <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
                        if (!ready_reg) begin
                            a1_reg    <= {key_reg[0], key_reg[1]};
                            a0_reg    <= {key_reg[2], key_reg[3]};
                            cnt_reg   <= '0;
                            state_reg <= ST_EXPAND;
                        end else begin
                            rnd_reg   <= 4'd1;
                            state_reg <= ST_ENC;
                        end
                    end
                end
                ST_EXPAND:
                begin
                    a1_reg  <= unit_out ^ a0_reg;
                    a0_reg  <= a1_reg;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(NumSteps - 1)) begin
                        ready_reg <= 1'b1;
                        rnd_reg   <= 4'd1;
                        state_reg <= ST_ENC;
                    end
                end
                ST_ENC:
                begin
                    // rkey_reg holds key rnd_reg-1
                    if (rnd_reg == 4'(NumRounds)) begin
                        data_reg  <= data_reg ^ rkey_reg;
                        rnd_reg   <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        data_reg <= unit_out;
                        rnd_reg  <= rnd_reg + 4'd1;
                    end
                end
                ST_OUT:
                begin
                    if (m_axis_tready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
